// ----- src/qte_pkg.sv -----
`default_nettype none
package qte_pkg;
	localparam int unsigned CordicStepsDef = 16;
	localparam int unsigned CordicStepsMax = 24;
	localparam int unsigned AngW = 28;
	localparam int unsigned VecW = 34;
	localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
	localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
	localparam logic signed [14:0] HalfPiQ13 = 15'sd12868;

	function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
		logic signed [AngW-1:0] r;
		case (i)
			5'd0: r = 28'sd13176795;
			5'd1: r = 28'sd7778716;
			5'd2: r = 28'sd4110060;
			5'd3: r = 28'sd2086331;
			5'd4: r = 28'sd1047214;
			5'd5: r = 28'sd524117;
			5'd6: r = 28'sd262123;
			5'd7: r = 28'sd131069;
			default: r = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [AngW-1:0] sat_pi(input logic signed [AngW-1:0] a);
		logic signed [AngW-1:0] r;
		r = a;
		if (a > PiQ24) r = PiQ24;
		if (a < -PiQ24) r = -PiQ24;
		return r;
	endfunction

	function automatic logic signed [16:0] to_q13(input logic signed [AngW-1:0] a);
		logic [AngW-1:0] m;
		logic [AngW-1:0] q;
		m = a[AngW-1] ? AngW'(-a) : AngW'(a);
		q = (m + AngW'(1024)) >> 11;
		return a[AngW-1] ? -$signed(17'(q)) : $signed(17'(q));
	endfunction
endpackage
`default_nettype wire

// ----- src/qte_cordic.sv -----
`default_nettype none
module qte_cordic #(
	parameter int unsigned CORDIC_STEPS = qte_pkg::CordicStepsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic signed [qte_pkg::VecW-1:0] vec_y,
	input wire logic signed [qte_pkg::VecW-1:0] vec_x,
	output logic signed [qte_pkg::AngW-1:0] angle
);
	localparam int unsigned N = (CORDIC_STEPS > qte_pkg::CordicStepsMax) ?
		qte_pkg::CordicStepsMax : CORDIC_STEPS;
	localparam int unsigned W = qte_pkg::VecW + 2;

	logic signed [W-1:0] x_s [N+1];
	logic signed [W-1:0] y_s [N+1];
	logic signed [qte_pkg::AngW-1:0] z_s [N+1];
	logic zero_s [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vec_x == '0) && (vec_y == '0);
			if (vec_x < 0 && vec_y >= 0) begin
				x_s[0] <= W'(vec_y); y_s[0] <= -W'(vec_x); z_s[0] <= qte_pkg::HalfPiQ24;
			end else if (vec_x < 0) begin
				x_s[0] <= -W'(vec_y); y_s[0] <= W'(vec_x); z_s[0] <= -qte_pkg::HalfPiQ24;
			end else begin
				x_s[0] <= W'(vec_x); y_s[0] <= W'(vec_y); z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + qte_pkg::atan_entry(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - qte_pkg::atan_entry(5'(i));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle <= '0;
		end else if (en) begin
			angle <= zero_s[N] ? '0 : qte_pkg::sat_pi(z_s[N]);
		end
	end
endmodule
`default_nettype wire

// ----- src/quaternion_to_euler_angles.sv -----
// channel | dir | tdata fields (low bit up)                      | tuser
// s_axis  | in  | quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48] | -
// m_axis  | out | roll[15:0] pitch[30:16] yaw[46:31] pad        | pitch_clamped
// Pipeline of 3 product stages, 29 square root stages and CORDIC_STEPS+2
// CORDIC stages, with CORDIC_STEPS capped at 24.
// One transaction per cycle while m_axis is not stalled; every stage advances together.
// A stall at m_axis holds the whole pipeline; s_axis_tready is high when m_axis_tready is high or m_axis_tvalid is low.
// Reset clears valid bits and angle registers only.
`default_nettype none
module quaternion_to_euler_angles #(
	parameter int unsigned CORDIC_STEPS = qte_pkg::CordicStepsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [63:0] s_axis_tdata, // quat_w, quat_x, quat_y, quat_z
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // roll_angle, pitch_angle, yaw_angle
	output logic m_axis_tuser // pitch_clamped
);
	localparam int unsigned NS = (CORDIC_STEPS > qte_pkg::CordicStepsMax) ?
		qte_pkg::CordicStepsMax : CORDIC_STEPS;
	localparam int unsigned SQ = 29;
	localparam int unsigned LAT = 3 + SQ + NS + 2;
	localparam int unsigned VW = qte_pkg::VecW;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = vld_q[LAT-1];

	// products
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[31:16]);
			yz_s1 <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[63:48]);
			xx_s1 <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
			yy_s1 <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]);
			wy_s1 <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
			zx_s1 <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[31:16]);
			wz_s1 <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[63:48]);
			xy_s1 <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[47:32]);
			zz_s1 <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[63:48]);
		end
	end

	logic signed [VW-1:0] sinr_s2, cosr_s2, sinp_s2, siny_s2, cosy_s2;
	localparam logic signed [VW-1:0] One = VW'(64'sd1 <<< 28);
	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s2 <= (VW'(wx_s1) + VW'(yz_s1)) <<< 1;
			cosr_s2 <= One - ((VW'(xx_s1) + VW'(yy_s1)) <<< 1);
			sinp_s2 <= (VW'(wy_s1) - VW'(zx_s1)) <<< 1;
			siny_s2 <= (VW'(wz_s1) + VW'(xy_s1)) <<< 1;
			cosy_s2 <= One - ((VW'(yy_s1) + VW'(zz_s1)) <<< 1);
		end
	end

	// 1 - s^2 for |s| < 2^28, and the clamp flag for |s| >= 1
	logic signed [VW-1:0] sinp_s3;
	logic clamp_s3;
	logic [56:0] rad_s3;
	logic [27:0] mag2;
	assign mag2 = sinp_s2[VW-1] ? 28'(-sinp_s2) : 28'(sinp_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			sinp_s3 <= sinp_s2;
			clamp_s3 <= (sinp_s2 >= One) || (sinp_s2 <= -One);
			rad_s3 <= (57'(1) << 56) - 57'(56'(mag2) * 56'(mag2));
		end
	end

	// square root, one result bit per stage
	logic [56:0] rem_r [SQ+1];
	logic [28:0] res_r [SQ+1];
	logic signed [VW-1:0] sp_r [SQ+1];
	logic cl_r [SQ+1];
	logic signed [VW-1:0] sr_r [SQ+1], cr_r [SQ+1], sy_r [SQ+1], cy_r [SQ+1];
	assign rem_r[0] = rad_s3;
	assign res_r[0] = '0;
	assign sp_r[0] = sinp_s3;
	assign cl_r[0] = clamp_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sr_r[0] <= sinr_s2; cr_r[0] <= cosr_s2;
			sy_r[0] <= siny_s2; cy_r[0] <= cosy_s2;
		end
	end
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam int unsigned B = SQ - 1 - k;
		always_ff @(posedge clk) begin
			if (en) begin
				if (59'(rem_r[k]) >= ((59'(res_r[k]) << (B + 1)) | (59'(1) << (2 * B)))) begin
					rem_r[k+1] <= 57'(59'(rem_r[k])
						- ((59'(res_r[k]) << (B + 1)) | (59'(1) << (2 * B))));
					res_r[k+1] <= res_r[k] | (29'(1) << B);
				end else begin
					rem_r[k+1] <= rem_r[k];
					res_r[k+1] <= res_r[k];
				end
				sp_r[k+1] <= sp_r[k]; cl_r[k+1] <= cl_r[k];
				sr_r[k+1] <= sr_r[k]; cr_r[k+1] <= cr_r[k];
				sy_r[k+1] <= sy_r[k]; cy_r[k+1] <= cy_r[k];
			end
		end
	end

	logic signed [qte_pkg::AngW-1:0] roll_a, pitch_a, yaw_a;
	qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (.clk, .arst_n, .en,
		.vec_y(sr_r[SQ]), .vec_x(cr_r[SQ]), .angle(roll_a));
	qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (.clk, .arst_n, .en,
		.vec_y(sy_r[SQ]), .vec_x(cy_r[SQ]), .angle(yaw_a));
	qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (.clk, .arst_n, .en,
		.vec_y(sp_r[SQ]), .vec_x($signed(VW'(res_r[SQ]))), .angle(pitch_a));

	logic signed [VW-1:0] spd [NS+3];
	logic cld [NS+3];
	assign spd[0] = sp_r[SQ];
	assign cld[0] = cl_r[SQ];
	for (genvar j = 0; j < NS + 2; j++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				spd[j+1] <= spd[j];
				cld[j+1] <= cld[j];
			end
		end
	end

	logic signed [16:0] pq;
	logic signed [14:0] pitch_o;
	always_comb begin
		pq = qte_pkg::to_q13(pitch_a);
		if (cld[NS+2]) pitch_o = spd[NS+2] > 0 ? qte_pkg::HalfPiQ13 : -qte_pkg::HalfPiQ13;
		else if (pq > 17'sd12868) pitch_o = qte_pkg::HalfPiQ13;
		else if (pq < -17'sd12868) pitch_o = -qte_pkg::HalfPiQ13;
		else pitch_o = 15'(pq);
	end

	logic [15:0] roll_o, yaw_o;
	assign roll_o = 16'(qte_pkg::to_q13(roll_a));
	assign yaw_o = 16'(qte_pkg::to_q13(yaw_a));
	assign m_axis_tdata = {1'b0, yaw_o, pitch_o, roll_o};
	assign m_axis_tuser = cld[NS+2];
endmodule
`default_nettype wire

// ----- src/qte_checker.sv -----
`default_nettype none
module qte_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic m_axis_tuser
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata[30:16] == 15'd12868 || m_axis_tdata[30:16] == 15'h4dbc))
		else $error("clamped pitch not at half pi");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[47])
		else $error("pad bit set");
endmodule

bind quaternion_to_euler_angles qte_props u_chk (.clk, .arst_n, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser);
`default_nettype wire

// ----- sim/qte_checker.sv -----
`default_nettype none
module qte_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [63:0] s_axis_tdata, // quat_w, quat_x, quat_y, quat_z
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [47:0] m_axis_tdata, // roll_angle, pitch_angle, yaw_angle
	input wire logic m_axis_tuser, // pitch_clamped
	output int errors,
	output int pending
);
	localparam int unsigned Steps = (qte_pkg::CordicStepsDef > qte_pkg::CordicStepsMax) ?
		qte_pkg::CordicStepsMax : qte_pkg::CordicStepsDef;
	localparam longint OneQ28 = 64'sd1 << 28;
	localparam longint PiQ24 = 64'sd52707179;
	localparam longint HalfPiQ24 = 64'sd26353589;
	localparam longint HalfPiQ13 = 64'sd12868;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic clamped;
	} euler_t;

	euler_t angles_due[$];

	function automatic longint arctan_step(input int i);
		longint tab[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069};
		if (i < 8)
			return tab[i];
		return 64'sd65536 >>> (i - 8);
	endfunction

	function automatic longint vector_angle(input longint sy, input longint cx);
		longint x, y, z, t, xs, ys;
		x = cx;
		y = sy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HalfPiQ24;
			end else begin
				x = -y;
				y = t;
				z = -HalfPiQ24;
			end
		end
		for (int i = 0; i < Steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += arctan_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= arctan_step(i);
			end
		end
		if (z > PiQ24)
			z = PiQ24;
		if (z < -PiQ24)
			z = -PiQ24;
		return z;
	endfunction

	function automatic longint round_q13(input longint a);
		if (a >= 0)
			return (a + 1024) >>> 11;
		return -(((-a) + 1024) >>> 11);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t quat_to_euler(input logic [63:0] q);
		longint w, x, y, z, sinr, cosr, sinp, siny, cosy, p;
		euler_t e;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		sinr = 2 * (w * x + y * z);
		cosr = OneQ28 - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = OneQ28 - 2 * (y * y + z * z);
		e.roll = 16'(round_q13(vector_angle(sinr, cosr)));
		e.yaw = 16'(round_q13(vector_angle(siny, cosy)));
		if (sinp >= OneQ28 || sinp <= -OneQ28) begin
			p = (sinp > 0) ? HalfPiQ13 : -HalfPiQ13;
			e.clamped = 1'b1;
		end else begin
			p = round_q13(vector_angle(sinp,
				longint'(int_sqrt((64'd1 << 56) - 64'(sinp * sinp)))));
			if (p > HalfPiQ13)
				p = HalfPiQ13;
			if (p < -HalfPiQ13)
				p = -HalfPiQ13;
			e.clamped = 1'b0;
		end
		e.pitch = 15'(p);
		return e;
	endfunction

	assign pending = angles_due.size();

	initial errors = 0;

	always @(posedge clk) begin
		euler_t want, got;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			angles_due.push_back(quat_to_euler(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.roll = m_axis_tdata[15:0];
			got.pitch = m_axis_tdata[30:16];
			got.yaw = m_axis_tdata[46:31];
			got.clamped = m_axis_tuser;
			if (angles_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("checker: unexpected result roll=%0d pitch=%0d yaw=%0d clamp=%0b",
						got.roll, got.pitch, got.yaw, got.clamped);
			end else begin
				want = angles_due.pop_front();
				if (want != got) begin
					errors++;
					if (errors <= 10)
						$display("checker: mismatch exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
							want.roll, want.pitch, want.yaw, want.clamped,
							got.roll, got.pitch, got.yaw, got.clamped);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
	localparam int Latency = qte_pkg::CordicStepsDef + 34;
	localparam int Limit = 300000;
	localparam int RandomItems = 1700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0; // quat_w, quat_x, quat_y, quat_z
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata; // roll_angle, pitch_angle, yaw_angle
	logic m_axis_tuser; // pitch_clamped
	int errors, pending;
	int cycles = 0;

	quaternion_to_euler_angles u_dut (.*);

	qte_checker u_checker (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > Limit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic offer(input logic [15:0] w, x, y, z);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x, w};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic idle_for(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_code();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [15:0] rand_q214();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic [63:0] unit_quat(input real lean);
		real c[4];
		real n;
		for (int i = 0; i < 4; i++)
			c[i] = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
		// push toward gimbal lock: w tracks y or -y
		if (lean > 0.0)
			c[2] = ((c[2] >= 0.0) ? 1.0 : -1.0) * (c[0] < 0.0 ? -c[0] : c[0]) +
				lean * c[2];
		n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
		if (n < 1.0e-6)
			return {48'd0, 16'sd16384};
		for (int i = 0; i < 4; i++)
			c[i] = c[i] / n * 16384.0;
		return {16'($rtoi(c[3])), 16'($rtoi(c[2])), 16'($rtoi(c[1])), 16'($rtoi(c[0]))};
	endfunction

	initial begin
		logic [63:0] q;
		int burst, k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(0, 0, 0, 0);
		offer(16384, 0, 0, 0);
		offer(-16384, 0, 0, 0);
		offer(0, 16384, 0, 0);
		offer(0, 0, 16384, 0);
		offer(0, 0, 0, 16384);
		offer(0, -16384, 0, 0);
		offer(0, 0, 0, -16384);
		offer(11586, 0, 11586, 0);
		offer(11586, 0, -11586, 0);
		offer(11585, 0, 11585, 0);
		offer(0, 11586, 0, -11586);
		offer(-32768, -32768, -32768, -32768);
		offer(32767, 32767, 32767, 32767);
		offer(-32768, 32767, -32768, 32767);
		offer(16384, 16384, 16384, 16384);
		offer(-16384, 16384, -16384, 16384);
		offer(8192, 8192, 8192, 8192);
		offer(1, -1, 1, -1);
		offer(11585, 11585, 0, 0);
		offer(0, 0, 11585, 11585);
		drain();

		k = 0;
		while (k < RandomItems) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && k < RandomItems) begin
				case ($urandom_range(0, 9))
					0, 1: q = {rand_code(), rand_code(), rand_code(), rand_code()};
					2: q = {rand_q214(), rand_q214(), rand_q214(), rand_q214()};
					3: q = unit_quat(0.002);
					default: q = unit_quat(0.0);
				endcase
				offer(q[15:0], q[31:16], q[47:32], q[63:48]);
				burst--;
				k++;
			end
			if (k == RandomItems / 2)
				drain();
			else if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 12));
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (Latency + 10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int mode, n;
		@(posedge arst_n);
		repeat (1500) begin
			@(posedge clk);
			m_axis_tready <= 1'b1;
		end
		// long hold while the sender keeps offering
		m_axis_tready <= 1'b0;
		n = 0;
		while (n < 400) begin
			@(posedge clk);
			n++;
		end
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(16, 96)) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 0);
					2: m_axis_tready <= ($urandom_range(0, 7) == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/qte_pkg.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles.sv
src/qte_checker.sv
sim/qte_checker.sv
sim/testbench.sv
